// ===== design/nth_prime_in_progression_core_assert.svh =====
// ----------------------------------------------------------------------------
// nth_prime_in_progression_core assertion macros
// property shorthands used by the core's checks
// ----------------------------------------------------------------------------
`ifndef NTH_PRIME_IN_PROGRESSION_CORE_ASSERT_SVH
`define NTH_PRIME_IN_PROGRESSION_CORE_ASSERT_SVH

// same-cycle implication
`define NPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/npp_pkg.sv =====
// ----------------------------------------------------------------------------
// npp_pkg
// shared widths and control structs of the progression prime search
// ----------------------------------------------------------------------------
`default_nettype none

package npp_pkg;

  localparam int VALUE_BITS    = 20;
  localparam int TERM_BITS     = VALUE_BITS + 1;
  localparam int DIV_BITS      = VALUE_BITS / 2 + 1;
  localparam int SQ_BITS       = 2 * DIV_BITS;
  localparam int REM_CNT_BITS  = $clog2(VALUE_BITS + 1);
  localparam int IN_DATA_BITS  = ((3 * VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic load;
    logic test_init;
    logic div_start;
    logic d_adv;
    logic count_inc;
    logic term_adv;
    logic set_hit;
    logic out_load;
  } npp_cmd_t;

  typedef struct packed {
    logic want_zero;
    logic step_zero;
    logic term_gt_limit;
    logic n_lt2;
    logic n_lt4;
    logic n_even;
    logic sq_gt_n;
    logic rem_done;
    logic rem_zero;
    logic count_hit;
    logic out_free;
  } npp_status_t;

endpackage

`default_nettype wire

// ===== design/npp_rem.sv =====
// ----------------------------------------------------------------------------
// npp_rem
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module npp_rem (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [npp_pkg::VALUE_BITS-1:0] dividend,
  input  logic [npp_pkg::DIV_BITS-1:0]   divisor,
  output logic                          done,
  output logic [npp_pkg::DIV_BITS-1:0]   remainder
);
  import npp_pkg::*;

  logic                    busy;
  logic [REM_CNT_BITS-1:0] cnt;
  logic [VALUE_BITS-1:0]   shreg;
  logic [DIV_BITS-1:0]     dvs;
  logic [DIV_BITS:0]       r_sh;
  logic [DIV_BITS:0]       r_next;

  always_comb begin
    r_sh   = {remainder, shreg[VALUE_BITS-1]};
    r_next = r_sh;
    if (r_sh >= {1'b0, dvs}) begin
      r_next = r_sh - {1'b0, dvs};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= REM_CNT_BITS'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == REM_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      shreg     <= {shreg[VALUE_BITS-2:0], 1'b0};
      remainder <= r_next[DIV_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== design/npp_dp.sv =====
// ----------------------------------------------------------------------------
// npp_dp
// term walk, trial divisor, prime count and result register
// ----------------------------------------------------------------------------
`default_nettype none

module npp_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [npp_pkg::VALUE_BITS-1:0]  start_value,
  input  logic [npp_pkg::VALUE_BITS-1:0]  stride,
  input  logic [npp_pkg::VALUE_BITS-1:0]  rank,
  input  logic                            cfg_we,
  input  logic [npp_pkg::VALUE_BITS-1:0]  cfg_wdata,
  input  logic                            out_ready,
  input  npp_pkg::npp_cmd_t               cmd,
  output npp_pkg::npp_status_t            status,
  output logic                            out_valid,
  output logic [npp_pkg::VALUE_BITS-1:0]  out_value,
  output logic                            out_found
);
  import npp_pkg::*;

  logic [VALUE_BITS-1:0] search_limit;
  logic [TERM_BITS-1:0]  term;
  logic [VALUE_BITS-1:0] step;
  logic [VALUE_BITS-1:0] want;
  logic [VALUE_BITS-1:0] count;
  logic [DIV_BITS-1:0]   d;
  logic [SQ_BITS-1:0]    sq;
  logic                  hit;
  logic [VALUE_BITS-1:0] n;
  logic                  rem_done;
  logic [DIV_BITS-1:0]   rem;

  assign n = term[VALUE_BITS-1:0];

  npp_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (n),
    .divisor   (d),
    .done      (rem_done),
    .remainder (rem)
  );

  always_comb begin
    status.want_zero     = (want == '0);
    status.step_zero     = (step == '0);
    status.term_gt_limit = (term > {1'b0, search_limit});
    status.n_lt2         = (n < VALUE_BITS'(2));
    status.n_lt4         = (n < VALUE_BITS'(4));
    status.n_even        = ~n[0];
    status.sq_gt_n       = (sq > SQ_BITS'(n));
    status.rem_done      = rem_done;
    status.rem_zero      = (rem == '0);
    status.count_hit     = (({1'b0, count} + 1'b1) == {1'b0, want});
    status.out_free      = ~out_valid | out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_limit <= '1;
      out_valid    <= 1'b0;
      hit          <= 1'b0;
    end else begin
      if (cfg_we) begin
        search_limit <= cfg_wdata;
      end
      if (cmd.load) begin
        hit <= 1'b0;
      end else if (cmd.set_hit) begin
        hit <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      term  <= {1'b0, start_value};
      step  <= stride;
      want  <= rank;
      count <= '0;
    end else begin
      if (cmd.term_adv) begin
        term <= term + {1'b0, step};
      end
      if (cmd.count_inc) begin
        count <= count + 1'b1;
      end
    end
    if (cmd.test_init) begin
      d  <= DIV_BITS'(3);
      sq <= SQ_BITS'(9);
    end else if (cmd.d_adv) begin
      d  <= d + DIV_BITS'(2);
      sq <= sq + SQ_BITS'({d, 2'b00}) + SQ_BITS'(4);
    end
    if (cmd.out_load) begin
      out_value <= hit ? n : '0;
      out_found <= hit;
    end
  end

endmodule

`default_nettype wire

// ===== design/npp_ctrl.sv =====
// ----------------------------------------------------------------------------
// npp_ctrl
// sequencer for the term walk and the trial division loop
// ----------------------------------------------------------------------------
`default_nettype none

module npp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  npp_pkg::npp_status_t status,
  output npp_pkg::npp_cmd_t    cmd
);
  import npp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SQ    = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_PRIME = 3'd4;
  localparam logic [2:0] S_COMP  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.want_zero || status.term_gt_limit) begin
          state_next = S_DONE;
        end else if (status.n_lt2) begin
          state_next = S_COMP;
        end else if (status.n_lt4) begin
          state_next = S_PRIME;
        end else if (status.n_even) begin
          state_next = S_COMP;
        end else begin
          cmd.test_init = 1'b1;
          state_next    = S_SQ;
        end
      end
      S_SQ: begin
        if (status.sq_gt_n) begin
          state_next = S_PRIME;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (status.rem_done) begin
          if (status.rem_zero) begin
            state_next = S_COMP;
          end else begin
            cmd.d_adv  = 1'b1;
            state_next = S_SQ;
          end
        end
      end
      S_PRIME: begin
        if (status.count_hit || status.step_zero) begin
          cmd.set_hit = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.count_inc = 1'b1;
          cmd.term_adv  = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_COMP: begin
        if (status.step_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.term_adv = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/nth_prime_in_progression_core.sv =====
// ----------------------------------------------------------------------------
// nth_prime_in_progression_core: rank-th prime of start + k*stride
// one request at a time; each term is screened (limit, below 2, 2 and 3, even), then trial-divided by odd divisors
// from 3 while divisor squared <= term; the result is loaded once the output register is free
// s_axis_tready rises in the same cycle as m_axis_tvalid; rst (sync, high) clears control, limit all ones
// ----------------------------------------------------------------------------
`default_nettype none

module nth_prime_in_progression_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [npp_pkg::VALUE_BITS-1:0]     cfg_wdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // start_value, stride, rank, zero pad
  input  logic [npp_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // prime_value, zero pad
  output logic [npp_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  // found
  output logic [0:0]                         m_axis_tuser
);
  import npp_pkg::*;

  npp_cmd_t              cmd;
  npp_status_t           status;
  logic [VALUE_BITS-1:0] out_value;
  logic                  out_found;

  npp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  npp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .start_value (s_axis_tdata[VALUE_BITS-1:0]),
    .stride      (s_axis_tdata[2*VALUE_BITS-1:VALUE_BITS]),
    .rank        (s_axis_tdata[3*VALUE_BITS-1:2*VALUE_BITS]),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .out_ready   (m_axis_tready),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (m_axis_tvalid),
    .out_value   (out_value),
    .out_found   (out_found)
  );

  assign m_axis_tdata = OUT_DATA_BITS'(out_value);
  assign m_axis_tuser = out_found;

  `include "nth_prime_in_progression_core_assert.svh"

  `NPP_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0, "miss with nonzero value")
  `NPP_ASSERT_NOW(a_hit_ge2, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata >= OUT_DATA_BITS'(2), "hit below two")
  `NPP_ASSERT_NEXT(a_one_request, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken while busy")

endmodule

`default_nettype wire
